[rtl/cps_pkg.sv]
package cps_pkg;

    localparam int SLOTS    = 24;
    localparam int TAG_BITS = 16;
    localparam int HANDLE_W = 5;
    localparam int TAG_IN_W = 16;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_IDLE  = 2'd3;

    typedef struct packed {
        logic        used;
        logic        running;
        logic [31:0] start;
        logic [31:0] calls;
        logic [63:0] total;
        logic [31:0] shortest;
        logic [31:0] longest;
    } slot_stats_t;

    typedef struct packed {
        logic                search;
        logic                is_begin;
        logic                any_match;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_BITS-1:0] tag;
        logic                wr_en;
        logic                wr_tag;
        slot_stats_t         wdata;
    } cell_cmd_t;

endpackage

[rtl/cycle_profiler_slots_core.sv]
// Flow: a taken start moves the item through the tag search cycle and the
// slot update cycle, then done pulses with the result registered.
// busy is high for the tag search cycle, and a new start is taken during
// the slot update cycle, so a new item can be taken while the last one is still being updated.
// The receiver cannot stall; each result is valid for the single done cycle.
// Reset (rst_n low, asynchronous) frees all slots and clears statistics
// at once, minimum to all ones; no clearing pass follows.
module cycle_profiler_slots_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    action,
    input  logic [cps_pkg::TAG_IN_W-1:0]  tag_id,
    input  logic [cps_pkg::HANDLE_W-1:0]  slot_handle,
    input  logic [31:0]                   now_cycles,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [cps_pkg::HANDLE_W-1:0]  slot_out,
    output logic [31:0]                   calls,
    output logic [63:0]                   total,
    output logic [31:0]                   shortest,
    output logic [31:0]                   longest,
    output logic                          running
);
    import cps_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SRCH, ST_UPD} state_t;

    state_t              state_reg;
    logic [1:0]          act_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [31:0]         now_reg;

    logic                done_reg;
    logic [1:0]          status_reg;
    logic [HANDLE_W-1:0] slot_reg;
    logic [31:0]         calls_reg;
    logic [63:0]         total_reg;
    logic [31:0]         shortest_reg;
    logic [31:0]         longest_reg;
    logic                running_reg;

    cell_cmd_t           cmd;
    logic [SLOTS:0]      free_chain;
    logic [SLOTS-1:0]    match_vec;
    logic [SLOTS-1:0]    sel_vec;
    slot_stats_t         stats_vec [SLOTS];

    slot_stats_t         cur;
    slot_stats_t         folded;
    slot_stats_t         res;
    logic [HANDLE_W-1:0] pick;
    logic                is_begin;
    logic                in_range;
    logic                accept;
    logic [1:0]          status_next;
    logic [HANDLE_W-1:0] slot_next;
    logic                zero_stats;

    assign accept     = start && !busy;
    assign busy       = (state_reg == ST_SRCH);
    assign is_begin   = (act_reg == ACT_BEGIN);
    assign in_range   = ({1'b0, handle_reg} < (HANDLE_W + 1)'(SLOTS));
    assign free_chain[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            cps_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (HANDLE_W'(g)),
                .cmd      (cmd),
                .free_in  (free_chain[g]),
                .free_out (free_chain[g+1]),
                .match    (match_vec[g]),
                .sel      (sel_vec[g]),
                .stats    (stats_vec[g])
            );
        end
    endgenerate

    // Selected slot read: sel_vec is one-hot or empty.
    always_comb
    begin
        cur  = '0;
        pick = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel_vec[i])
            begin
                cur  = cur | stats_vec[i];
                pick = pick | HANDLE_W'(i);
            end
        end
    end

    cps_fold u_fold (
        .cur    (cur),
        .now    (now_reg),
        .folded (folded)
    );

    always_comb
    begin
        cmd           = '0;
        cmd.search    = (state_reg == ST_SRCH);
        cmd.is_begin  = is_begin;
        cmd.any_match = |match_vec;
        cmd.handle    = handle_reg;
        cmd.tag       = tag_reg;
        res           = cur;
        status_next   = STAT_OK;
        slot_next     = handle_reg;
        zero_stats    = 1'b0;

        if (is_begin)
        begin
            slot_next = pick;
            if (|sel_vec)
            begin
                res.used    = 1'b1;
                res.running = 1'b1;
                res.start   = now_reg;
                cmd.wr_tag  = 1'b1;
                cmd.wr_en   = (state_reg == ST_UPD);
            end
            else
            begin
                status_next = STAT_FULL;
                zero_stats  = 1'b1;
            end
        end
        else if (!in_range)
        begin
            status_next = STAT_RANGE;
            zero_stats  = 1'b1;
        end
        else if (act_reg == ACT_END)
        begin
            if (cur.running)
            begin
                res       = folded;
                cmd.wr_en = (state_reg == ST_UPD);
            end
            else
            begin
                status_next = STAT_IDLE;
            end
        end
        else
        begin
            status_next = cur.used ? STAT_OK : STAT_IDLE;
        end
        cmd.wdata = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            done_reg     <= 1'b0;
            status_reg   <= STAT_OK;
            slot_reg     <= '0;
            calls_reg    <= '0;
            total_reg    <= '0;
            shortest_reg <= '0;
            longest_reg  <= '0;
            running_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_UPD);
            if (state_reg == ST_UPD)
            begin
                status_reg   <= status_next;
                slot_reg     <= slot_next;
                calls_reg    <= zero_stats ? 32'd0 : res.calls;
                total_reg    <= zero_stats ? 64'd0 : res.total;
                shortest_reg <= zero_stats ? 32'd0 : res.shortest;
                longest_reg  <= zero_stats ? 32'd0 : res.longest;
                running_reg  <= zero_stats ? 1'b0 : res.running;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_SRCH;
                    end
                end
                ST_SRCH:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    state_reg <= accept ? ST_SRCH : ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Hold the transferred item for the search and update cycles.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= action;
            tag_reg    <= TAG_BITS'({16'd0, tag_id});
            handle_reg <= slot_handle;
            now_reg    <= now_cycles;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign slot_out = slot_reg;
    assign calls    = calls_reg;
    assign total    = total_reg;
    assign shortest = shortest_reg;
    assign longest  = longest_reg;
    assign running  = running_reg;

    a_done_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPD))
        else $error("done without an update cycle");

    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(sel_vec))
        else $error("more than one slot selected");

    a_match_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> $onehot0(match_vec))
        else $error("tag held by more than one slot");

    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_FULL) |-> (slot_out == '0 && calls == 32'd0 && !running))
        else $error("table full result carries data");

endmodule

[rtl/cps_cell.sv]
module cps_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [cps_pkg::HANDLE_W-1:0]  idx,
    input  cps_pkg::cell_cmd_t            cmd,
    input  logic                          free_in,
    output logic                          free_out,
    output logic                          match,
    output logic                          sel,
    output cps_pkg::slot_stats_t          stats
);
    import cps_pkg::*;

    logic                used_reg;
    logic                running_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [31:0]         start_reg;
    logic [31:0]         calls_reg;
    logic [63:0]         total_reg;
    logic [31:0]         shortest_reg;
    logic [31:0]         longest_reg;
    logic                match_reg;
    logic                take_reg;
    logic                match_next;
    logic                take_next;

    // Free-slot priority ripples from cell 0 upward.
    assign free_out   = free_in | ~used_reg;
    assign take_next  = ~used_reg & ~free_in;
    assign match_next = used_reg && (tag_reg == cmd.tag);

    assign match = match_reg;
    assign sel   = cmd.is_begin ? (cmd.any_match ? match_reg : take_reg)
                                : (cmd.handle == idx);

    assign stats.used     = used_reg;
    assign stats.running  = running_reg;
    assign stats.start    = start_reg;
    assign stats.calls    = calls_reg;
    assign stats.total    = total_reg;
    assign stats.shortest = shortest_reg;
    assign stats.longest  = longest_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= 1'b0;
            running_reg  <= 1'b0;
            tag_reg      <= '0;
            calls_reg    <= '0;
            total_reg    <= '0;
            shortest_reg <= '1;
            longest_reg  <= '0;
            match_reg    <= 1'b0;
            take_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.search)
            begin
                match_reg <= match_next;
                take_reg  <= take_next;
            end
            if (cmd.wr_en && sel)
            begin
                used_reg     <= cmd.wdata.used;
                running_reg  <= cmd.wdata.running;
                calls_reg    <= cmd.wdata.calls;
                total_reg    <= cmd.wdata.total;
                shortest_reg <= cmd.wdata.shortest;
                longest_reg  <= cmd.wdata.longest;
                if (cmd.wr_tag)
                begin
                    tag_reg <= cmd.tag;
                end
            end
        end
    end

    // Start stamp is only read while running, and begin writes it first.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && sel)
        begin
            start_reg <= cmd.wdata.start;
        end
    end

endmodule

[rtl/cps_fold.sv]
module cps_fold (
    input  cps_pkg::slot_stats_t cur,
    input  logic [31:0]          now,
    output cps_pkg::slot_stats_t folded
);
    import cps_pkg::*;

    logic [31:0] elapsed;

    assign elapsed = now - cur.start;

    always_comb
    begin
        folded          = cur;
        folded.running  = 1'b0;
        folded.calls    = cur.calls + 32'd1;
        folded.total    = cur.total + {32'd0, elapsed};
        folded.shortest = (elapsed < cur.shortest) ? elapsed : cur.shortest;
        folded.longest  = (elapsed > cur.longest) ? elapsed : cur.longest;
    end

endmodule

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cps_pkg::*;

    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_LIMIT  = 200;
    localparam int RANDOM_ITEMS = 700;

    typedef struct packed {
        logic [1:0]          status;
        logic [HANDLE_W-1:0] slot;
        logic [31:0]         calls;
        logic [63:0]         total;
        logic [31:0]         shortest;
        logic [31:0]         longest;
        logic                running;
    } profile_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          action;
    logic [TAG_IN_W-1:0] tag_id;
    logic [HANDLE_W-1:0] slot_handle;
    logic [31:0]         now_cycles;
    logic                done;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] slot_out;
    logic [31:0]         calls;
    logic [63:0]         total;
    logic [31:0]         shortest;
    logic [31:0]         longest;
    logic                running;

    cycle_profiler_slots_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .tag_id      (tag_id),
        .slot_handle (slot_handle),
        .now_cycles  (now_cycles),
        .done        (done),
        .status      (status),
        .slot_out    (slot_out),
        .calls       (calls),
        .total       (total),
        .shortest    (shortest),
        .longest     (longest),
        .running     (running)
    );

    // Shadow copy of the slot table
    slot_stats_t     slot_table [SLOTS];
    logic [31:0]     slot_tags  [SLOTS];
    profile_result_t pending_results [$];

    int unsigned error_count;
    int unsigned stall_cycles;
    int unsigned n_begin, n_end, n_read, n_full, n_range, n_idle, n_timed;
    bit          no_gaps;
    logic [31:0] wall_clock;
    logic [15:0] tag_pool [16];

    initial clk = 1'b0;

    always #2 clk = ~clk;

    function automatic profile_result_t profile_step(input logic [1:0] act,
                                                     input logic [TAG_IN_W-1:0] tag,
                                                     input logic [HANDLE_W-1:0] hnd,
                                                     input logic [31:0] now);
        profile_result_t r;
        logic [31:0]     key;
        logic [31:0]     elapsed;
        int              pick;
        bit              found;
        r     = '0;
        key   = 32'(tag) & 32'((33'd1 << TAG_BITS) - 33'd1);
        pick  = SLOTS;
        found = 1'b0;
        if (act == ACT_BEGIN)
        begin
            // a matching tag wins over a lower free slot
            for (int i = 0; i < SLOTS; i++)
            begin
                if (!slot_table[i].used)
                begin
                    if (!found)
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                else if (slot_tags[i] == key)
                begin
                    pick  = i;
                    found = 1'b1;
                    break;
                end
            end
            if (!found)
            begin
                r.status = STAT_FULL;
                return r;
            end
            slot_tags[pick]          = key;
            slot_table[pick].used    = 1'b1;
            slot_table[pick].running = 1'b1;
            slot_table[pick].start   = now;
            r.status = STAT_OK;
            r.slot   = HANDLE_W'(pick);
        end
        else if (int'(hnd) >= SLOTS)
        begin
            r.status = STAT_RANGE;
            r.slot   = hnd;
            return r;
        end
        else if (act == ACT_END)
        begin
            r.slot = hnd;
            if (!slot_table[hnd].running)
            begin
                r.status = STAT_IDLE;
            end
            else
            begin
                elapsed = now - slot_table[hnd].start;
                slot_table[hnd].total = slot_table[hnd].total + 64'(elapsed);
                slot_table[hnd].calls = slot_table[hnd].calls + 32'd1;
                if (elapsed < slot_table[hnd].shortest)
                    slot_table[hnd].shortest = elapsed;
                if (elapsed > slot_table[hnd].longest)
                    slot_table[hnd].longest = elapsed;
                slot_table[hnd].running = 1'b0;
                r.status = STAT_OK;
            end
        end
        else
        begin
            r.slot   = hnd;
            r.status = slot_table[hnd].used ? STAT_OK : STAT_IDLE;
        end
        r.calls    = slot_table[r.slot].calls;
        r.total    = slot_table[r.slot].total;
        r.shortest = slot_table[r.slot].shortest;
        r.longest  = slot_table[r.slot].longest;
        r.running  = slot_table[r.slot].running;
        return r;
    endfunction

    task automatic take_gap();
        int unsigned n;
        if (!no_gaps && $urandom_range(99) < 19)
        begin
            n = $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            action      <= 2'($urandom);
            tag_id      <= TAG_IN_W'($urandom);
            slot_handle <= HANDLE_W'($urandom);
            now_cycles  <= $urandom;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic issue_event(input logic [1:0] act, input logic [TAG_IN_W-1:0] tag,
                               input logic [HANDLE_W-1:0] hnd, input logic [31:0] now);
        profile_result_t r;
        take_gap();
        @(negedge clk);
        start       <= 1'b1;
        action      <= act;
        tag_id      <= tag;
        slot_handle <= hnd;
        now_cycles  <= now;
        do @(posedge clk); while (busy);
        r = profile_step(act, tag, hnd, now);
        pending_results.push_back(r);
        case (act)
            ACT_BEGIN: n_begin++;
            ACT_END:   n_end++;
            default:   n_read++;
        endcase
        if (r.status == STAT_FULL)  n_full++;
        if (r.status == STAT_RANGE) n_range++;
        if (r.status == STAT_IDLE)  n_idle++;
        if (act == ACT_END && r.status == STAT_OK) n_timed++;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, name,
                     exp_v, act_v);
            error_count++;
        end
    endtask

    // Check every result transfer against the oldest prediction
    always @(posedge clk)
    begin : result_check
        profile_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, status %0d slot %0d",
                         $realtime, status, slot_out);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("status",   64'(exp_r.status),   64'(status));
                check_field("slot_out", 64'(exp_r.slot),     64'(slot_out));
                check_field("calls",    64'(exp_r.calls),    64'(calls));
                check_field("total",    exp_r.total,         total);
                check_field("shortest", 64'(exp_r.shortest), 64'(shortest));
                check_field("longest",  64'(exp_r.longest),  64'(longest));
                check_field("running",  64'(exp_r.running),  64'(running));
            end
        end
    end

    // Stop a hung run: count cycles with no transfer in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic test_empty_table();
        issue_event(ACT_READ, 16'h0000, 5'd0, 32'd0);
        issue_event(ACT_READ, 16'hFFFF, HANDLE_W'(SLOTS - 1), 32'hFFFF_FFFF);
        issue_event(ACT_READ, 16'h0000, HANDLE_W'(SLOTS), 32'd0);
        issue_event(ACT_READ, 16'h0000, 5'd31, 32'd0);
        issue_event(ACT_END, 16'h0000, 5'd5, 32'd100);
        issue_event(ACT_END, 16'h0000, 5'd31, 32'd100);
        issue_event(ACT_SPARE, 16'h0000, 5'd0, 32'd0);
        issue_event(ACT_SPARE, 16'h0000, 5'd30, 32'd0);
    endtask

    task automatic test_timing_basic();
        issue_event(ACT_BEGIN, 16'h0000, 5'd0, 32'hFFFF_FFF0);
        issue_event(ACT_READ, 16'h0000, 5'd0, 32'd0);
        // counter wraps between begin and end
        issue_event(ACT_END, 16'h0000, 5'd0, 32'h0000_0010);
        issue_event(ACT_BEGIN, 16'hFFFF, 5'd31, 32'd1);
        issue_event(ACT_END, 16'h0000, 5'd1, 32'd0);
        issue_event(ACT_BEGIN, 16'h0000, 5'd0, 32'd100);
        issue_event(ACT_END, 16'h0000, 5'd0, 32'd100);
        issue_event(ACT_END, 16'h0000, 5'd0, 32'd5);
        issue_event(ACT_READ, 16'h0000, 5'd0, 32'd0);
    endtask

    task automatic test_restart();
        issue_event(ACT_BEGIN, 16'h1234, 5'd0, 32'd10);
        issue_event(ACT_BEGIN, 16'h1234, 5'd0, 32'd50);
        issue_event(ACT_READ, 16'h0000, 5'd2, 32'd0);
        issue_event(ACT_END, 16'h0000, 5'd2, 32'd60);
    endtask

    task automatic test_random_traffic();
        int unsigned sel;
        int          live [$];
        logic [31:0] elapsed;
        logic [HANDLE_W-1:0] hnd;
        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        tag_pool[2] = 16'h1234;
        for (int i = 3; i < 16; i++) tag_pool[i] = 16'($urandom);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_gaps = (n >= 300 && n < 450);
            wall_clock = wall_clock + $urandom_range(1, 5000);
            sel = $urandom_range(99);
            if (sel < 35)
            begin
                if ($urandom_range(99) < 4)
                    issue_event(ACT_BEGIN, 16'($urandom), 5'($urandom), wall_clock);
                else
                    issue_event(ACT_BEGIN, tag_pool[$urandom_range(15)], 5'($urandom),
                                wall_clock);
            end
            else if (sel < 70)
            begin
                live.delete();
                for (int i = 0; i < SLOTS; i++)
                    if (slot_table[i].running) live.push_back(i);
                if (live.size() > 0 && $urandom_range(99) < 80)
                begin
                    hnd = HANDLE_W'(live[$urandom_range(live.size() - 1)]);
                    case ($urandom_range(9))
                        0:       elapsed = $urandom;
                        1:       elapsed = 32'hFFFF_FFFF - 32'($urandom_range(3));
                        2:       elapsed = 32'($urandom_range(3));
                        default: elapsed = 32'($urandom_range(1, 100000));
                    endcase
                    issue_event(ACT_END, 16'($urandom), hnd,
                                slot_table[hnd].start + elapsed);
                end
                else
                begin
                    issue_event(ACT_END, 16'($urandom), 5'($urandom), $urandom);
                end
            end
            else if (sel < 95)
            begin
                issue_event(ACT_READ, 16'($urandom), 5'($urandom), $urandom);
            end
            else
            begin
                issue_event(ACT_SPARE, 16'($urandom), 5'($urandom), $urandom);
            end
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_table_full();
        bit full_seen;
        full_seen = 1'b0;
        for (int n = 0; n <= SLOTS && !full_seen; n++)
        begin
            issue_event(ACT_BEGIN, 16'($urandom), 5'd0, $urandom);
            full_seen = (pending_results[$].status == STAT_FULL);
        end
        // existing tags still get their slot once the table is full
        issue_event(ACT_BEGIN, tag_pool[1], 5'd0, 32'd7);
        issue_event(ACT_READ, 16'h0000, HANDLE_W'(SLOTS - 1), 32'd0);
        issue_event(ACT_END, 16'h0000, HANDLE_W'(SLOTS - 1), 32'h8000_0000);
        issue_event(ACT_READ, 16'h0000, HANDLE_W'(SLOTS - 1), 32'd0);
    endtask

    initial
    begin
        int unsigned waited;
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_BEGIN;
        tag_id      = '0;
        slot_handle = '0;
        now_cycles  = '0;
        error_count = 0;
        stall_cycles = 0;
        no_gaps     = 1'b0;
        wall_clock  = 32'h1000_0000;
        {n_begin, n_end, n_read, n_full, n_range, n_idle, n_timed} = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_table[i] = '0;
            slot_table[i].shortest = '1;
            slot_tags[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_timing_basic();
        test_restart();
        test_random_traffic();
        test_table_full();

        @(negedge clk);
        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t ns: %0d results never arrived", $realtime,
                     pending_results.size());
            error_count++;
        end

        $display("Covered %0d begins, %0d ends (%0d timed), %0d reads", n_begin, n_end,
                 n_timed, n_read);
        $display("Statuses: %0d table full, %0d out of range, %0d idle; %0d errors",
                 n_full, n_range, n_idle, error_count);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
rtl/cps_pkg.sv
rtl/cps_cell.sv
rtl/cps_fold.sv
rtl/cycle_profiler_slots_core.sv
tb/tb_top.sv
